### design/mwpi_pkg.sv
// ----------------------------------------------------------------------------
// mwpi_pkg
// Shared constants, register codes and control types of the mecanum wheel
// speed controller.
// ----------------------------------------------------------------------------
package mwpi_pkg;

  localparam int WHEELS              = 4;
  localparam int GAIN_FRAC_BITS_DEF  = 8;
  localparam int GEOM_FRAC_BITS      = 16;

  localparam int VEL_W   = 16;
  localparam int GAIN_W  = 16;
  localparam int GEOM_W  = 16;
  localparam int LIM_W   = 14;
  localparam int DUTY_W  = 14;
  localparam int ACC_W   = 15;
  localparam int BIAS_W  = 19;
  localparam int ROT_W   = VEL_W + GEOM_W + 1;
  localparam int IDX_W   = 3;

  localparam logic [IDX_W-1:0] REG_GAIN_P      = 3'd0;
  localparam logic [IDX_W-1:0] REG_GAIN_I      = 3'd1;
  localparam logic [IDX_W-1:0] REG_GEOMETRY    = 3'd2;
  localparam logic [IDX_W-1:0] REG_PI_LIMIT    = 3'd3;
  localparam logic [IDX_W-1:0] REG_DRIVE_LIMIT = 3'd4;

  localparam logic signed [GAIN_W-1:0] GAIN_P_RST      = -16'sd2560;
  localparam logic signed [GAIN_W-1:0] GAIN_I_RST      = -16'sd2560;
  localparam logic        [GEOM_W-1:0] GEOMETRY_RST    = 16'd11862;
  localparam logic        [LIM_W-1:0]  PI_LIMIT_RST    = 14'd8400;
  localparam logic        [LIM_W-1:0]  DRIVE_LIMIT_RST = 14'd8400;

  // wheel order A, B, C, D: set bit means the term enters negated
  localparam logic [WHEELS-1:0] SIGN_X_NEG = 4'b0101;
  localparam logic [WHEELS-1:0] SIGN_Z_NEG = 4'b1001;

  typedef struct packed {
    logic tgt_en;
    logic mul_en;
    logic upd_en;
  } ctl_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic        [LIM_W-1:0]  pi_limit;
    logic        [LIM_W-1:0]  drive_limit;
  } lane_cfg_t;

endpackage

### design/mwpi_lane.sv
// ----------------------------------------------------------------------------
// mwpi_lane
// One wheel: target from body velocity, bias, incremental PI update with
// saturation and drive clamp.
// ----------------------------------------------------------------------------
module mwpi_lane
  import mwpi_pkg::*;
#(
  parameter int LANE           = 0,
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ctl_t                     ctl,
  input  lane_cfg_t                cfg,
  input  logic signed [VEL_W-1:0]  vel_x,
  input  logic signed [VEL_W-1:0]  vel_y,
  input  logic signed [ROT_W-1:0]  rot,
  input  logic signed [VEL_W-1:0]  count,
  output logic        [DUTY_W-1:0] duty,
  output logic                     fwd
);

  localparam int TS_W = ROT_W + 2;
  localparam int SW   = (((ACC_W + GAIN_FRAC_BITS) > (GAIN_W + BIAS_W + 1)) ?
                         (ACC_W + GAIN_FRAC_BITS) : (GAIN_W + BIAS_W + 1)) + 2;
  localparam int PP_W = GAIN_W + BIAS_W + 1;
  localparam int PI_W = GAIN_W + BIAS_W;

  logic signed [BIAS_W-1:0] bias_r, bias_nxt;
  logic signed [BIAS_W-1:0] prev_r, prev_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [PP_W-1:0]   prod_p_r, prod_p_nxt;
  logic signed [PI_W-1:0]   prod_i_r, prod_i_nxt;

  logic signed [VEL_W+1:0]  lin;
  logic signed [TS_W-1:0]   tsum;
  logic signed [TS_W-1:0]   tsum_adj;
  logic signed [TS_W-1:0]   target_full;
  logic signed [BIAS_W:0]   diff;
  logic signed [SW-1:0]     sum;
  logic signed [SW-1:0]     sum_adj;
  logic signed [SW-1:0]     quot;
  logic signed [SW-1:0]     plim;
  logic signed [ACC_W-1:0]  dlim;
  logic signed [ACC_W-1:0]  drive;
  logic signed [ACC_W-1:0]  drive_abs;

  always_comb begin
    if (SIGN_X_NEG[LANE]) begin
      lin = 18'(vel_y) - 18'(vel_x);
    end else begin
      lin = 18'(vel_y) + 18'(vel_x);
    end
    if (SIGN_Z_NEG[LANE]) begin
      tsum = (TS_W'(lin) <<< GEOM_FRAC_BITS) - TS_W'(rot);
    end else begin
      tsum = (TS_W'(lin) <<< GEOM_FRAC_BITS) + TS_W'(rot);
    end
    tsum_adj    = tsum + (tsum[TS_W-1] ?
                  TS_W'({GEOM_FRAC_BITS{1'b1}}) : TS_W'(0));
    target_full = tsum_adj >>> GEOM_FRAC_BITS;
    bias_nxt    = BIAS_W'(count) - target_full[BIAS_W-1:0];

    diff       = (BIAS_W+1)'(bias_r) - (BIAS_W+1)'(prev_r);
    prod_p_nxt = PP_W'(cfg.gain_p) * PP_W'(diff);
    prod_i_nxt = PI_W'(cfg.gain_i) * PI_W'(bias_r);

    sum     = (SW'(acc_r) <<< GAIN_FRAC_BITS) + SW'(prod_p_r) + SW'(prod_i_r);
    sum_adj = sum + (sum[SW-1] ? SW'({GAIN_FRAC_BITS{1'b1}}) : SW'(0));
    quot    = sum_adj >>> GAIN_FRAC_BITS;
    plim    = SW'($signed({1'b0, cfg.pi_limit}));
    if (quot > plim) begin
      acc_nxt = plim[ACC_W-1:0];
    end else if (quot < -plim) begin
      acc_nxt = -plim[ACC_W-1:0];
    end else begin
      acc_nxt = quot[ACC_W-1:0];
    end

    dlim = $signed({1'b0, cfg.drive_limit});
    if (acc_nxt > dlim) begin
      drive = dlim;
    end else if (acc_nxt < -dlim) begin
      drive = -dlim;
    end else begin
      drive = acc_nxt;
    end
    drive_abs = drive[ACC_W-1] ? -drive : drive;
    duty      = drive_abs[DUTY_W-1:0];
    fwd       = !drive[ACC_W-1] && (drive != '0);
    prev_nxt  = bias_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.tgt_en) begin
      bias_r <= bias_nxt;
    end
    if (ctl.mul_en) begin
      prod_p_r <= prod_p_nxt;
      prod_i_r <= prod_i_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      prev_r <= '0;
    end else if (ctl.upd_en) begin
      acc_r  <= acc_nxt;
      prev_r <= prev_nxt;
    end
  end

endmodule

### design/mwpi_merge.sv
// ----------------------------------------------------------------------------
// mwpi_merge
// Result register: collects the four lane drives into one transaction and
// holds it until the downstream side takes it.
// ----------------------------------------------------------------------------
module mwpi_merge
  import mwpi_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           load,
  input  logic [WHEELS-1:0][DUTY_W-1:0]  lane_duty,
  input  logic [WHEELS-1:0]              lane_fwd,
  input  logic                           out_stall,
  output logic                           out_valid,
  output logic                           free,
  output logic [WHEELS-1:0][DUTY_W-1:0]  duty,
  output logic [WHEELS-1:0]              fwd
);

  logic                          valid_r;
  logic [WHEELS-1:0][DUTY_W-1:0] duty_r;
  logic [WHEELS-1:0]             fwd_r;

  assign free      = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign duty      = duty_r;
  assign fwd       = fwd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      duty_r <= lane_duty;
      fwd_r  <= lane_fwd;
    end
  end

endmodule

### design/mecanum_wheel_pi_speed_control_core.sv
// ----------------------------------------------------------------------------
// mecanum_wheel_pi_speed_control_core
// Mecanum inverse kinematics and four incremental PI speed loops, one lane
// per wheel, with a shared rotation multiplier and a result register.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_stall  | vel_x, vel_y, vel_rot, count_a..count_d
//  out     | out_valid / out_stall| duty_a..duty_d, fwd_a..fwd_d
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  Steps of a transaction, in order: accept, rotation product, wheel targets,
//  gain products, accumulate and load of the result register.
//  The rotation and gain products are registered; input waits until idle.
//  The last step waits while a previous result is held by out_stall.
//  Reset restores the register defaults and clears accumulators and previous biases.
// ----------------------------------------------------------------------------
module mecanum_wheel_pi_speed_control_core
  import mwpi_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [VEL_W-1:0]  in_vel_x,
  input  logic signed [VEL_W-1:0]  in_vel_y,
  input  logic signed [VEL_W-1:0]  in_vel_rot,
  input  logic signed [VEL_W-1:0]  in_count_a,
  input  logic signed [VEL_W-1:0]  in_count_b,
  input  logic signed [VEL_W-1:0]  in_count_c,
  input  logic signed [VEL_W-1:0]  in_count_d,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic        [DUTY_W-1:0] out_duty_a,
  output logic        [DUTY_W-1:0] out_duty_b,
  output logic        [DUTY_W-1:0] out_duty_c,
  output logic        [DUTY_W-1:0] out_duty_d,
  output logic                     out_fwd_a,
  output logic                     out_fwd_b,
  output logic                     out_fwd_c,
  output logic                     out_fwd_d,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic        [IDX_W-1:0]  cfg_index,
  input  logic        [GAIN_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROT,
    S_TGT,
    S_MUL,
    S_ACC
  } state_t;

  state_t                   state_r, state_nxt;
  logic signed [VEL_W-1:0]  vx_r, vy_r, vz_r;
  logic signed [VEL_W-1:0]  cnt_r [WHEELS];
  logic signed [ROT_W-1:0]  rot_r, rot_nxt;

  logic signed [GAIN_W-1:0] gain_p_r, gain_i_r;
  logic        [GEOM_W-1:0] geom_r;
  logic        [LIM_W-1:0]  pi_limit_r, drive_limit_r;

  ctl_t                          ctl;
  lane_cfg_t                     lane_cfg;
  logic                          accept;
  logic                          free;
  logic [WHEELS-1:0][DUTY_W-1:0] lane_duty, duty;
  logic [WHEELS-1:0]             lane_fwd, fwd;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  assign ctl.tgt_en = (state_r == S_TGT);
  assign ctl.mul_en = (state_r == S_MUL);
  assign ctl.upd_en = (state_r == S_ACC) && free;

  assign lane_cfg.gain_p      = gain_p_r;
  assign lane_cfg.gain_i      = gain_i_r;
  assign lane_cfg.pi_limit    = pi_limit_r;
  assign lane_cfg.drive_limit = drive_limit_r;

  assign rot_nxt = ROT_W'(vz_r) * ROT_W'($signed({1'b0, geom_r}));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_ROT;
        end
      end
      S_ROT: state_nxt = S_TGT;
      S_TGT: state_nxt = S_MUL;
      S_MUL: state_nxt = S_ACC;
      S_ACC: begin
        if (free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    if (accept) begin
      vx_r     <= in_vel_x;
      vy_r     <= in_vel_y;
      vz_r     <= in_vel_rot;
      cnt_r[0] <= in_count_a;
      cnt_r[1] <= in_count_b;
      cnt_r[2] <= in_count_c;
      cnt_r[3] <= in_count_d;
    end
    if (state_r == S_ROT) begin
      rot_r <= rot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r      <= GAIN_P_RST;
      gain_i_r      <= GAIN_I_RST;
      geom_r        <= GEOMETRY_RST;
      pi_limit_r    <= PI_LIMIT_RST;
      drive_limit_r <= DRIVE_LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GAIN_P:      gain_p_r      <= cfg_data;
        REG_GAIN_I:      gain_i_r      <= cfg_data;
        REG_GEOMETRY:    geom_r        <= cfg_data;
        REG_PI_LIMIT:    pi_limit_r    <= cfg_data[LIM_W-1:0];
        REG_DRIVE_LIMIT: drive_limit_r <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar w = 0; w < WHEELS; w++) begin : g_lane
    mwpi_lane #(
      .LANE           (w),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .cfg   (lane_cfg),
      .vel_x (vx_r),
      .vel_y (vy_r),
      .rot   (rot_r),
      .count (cnt_r[w]),
      .duty  (lane_duty[w]),
      .fwd   (lane_fwd[w])
    );
  end

  mwpi_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (ctl.upd_en),
    .lane_duty (lane_duty),
    .lane_fwd  (lane_fwd),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .free      (free),
    .duty      (duty),
    .fwd       (fwd)
  );

  assign out_duty_a = duty[0];
  assign out_duty_b = duty[1];
  assign out_duty_c = duty[2];
  assign out_duty_d = duty[3];
  assign out_fwd_a  = fwd[0];
  assign out_fwd_b  = fwd[1];
  assign out_fwd_c  = fwd[2];
  assign out_fwd_d  = fwd[3];

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.upd_en |-> !(out_valid && out_stall))
    else $error("result register overwritten while held");

  a_accept_reaches_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> ##4 (state_r == S_ACC))
    else $error("transaction did not reach accumulate step");

  a_result_from_acc: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_ACC))
    else $error("result appeared without an accumulate step");
`endif

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the mecanum wheel speed controller core. Control
// ticks are queued phase by phase and issued by a clocked driver. Each issued
// tick goes through a local model of the wheel targets and the four PI
// loops. A clocked monitor compares every drive result with the oldest
// prediction. Register settings change only between phases, once the core
// has drained. Both channels idle at random in bursts. The final phase runs
// without idling.
// ----------------------------------------------------------------------------
module tb_top
  import mwpi_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 20;
  localparam int GAIN_FRAC      = GAIN_FRAC_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASES         = 8;
  localparam int PHASE_TICKS    = 210;
  localparam int TAIL_CYCLES    = 8;

  localparam logic [VEL_W-1:0] VEL_MAX = 16'h7FFF;
  localparam logic [VEL_W-1:0] VEL_MIN = 16'h8000;
  localparam logic [VEL_W-1:0] VEL_ONES = 16'hFFFF;

  typedef struct packed {
    logic [VEL_W-1:0]             vel_x;
    logic [VEL_W-1:0]             vel_y;
    logic [VEL_W-1:0]             vel_rot;
    logic [WHEELS-1:0][VEL_W-1:0] count;
  } tick_cmd_t;

  typedef struct packed {
    logic [WHEELS-1:0][DUTY_W-1:0] duty;
    logic [WHEELS-1:0]             fwd;
  } wheel_drive_t;

  localparam int CMD_W = $bits(tick_cmd_t);

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [VEL_W-1:0]  in_vel_x = '0;
  logic signed [VEL_W-1:0]  in_vel_y = '0;
  logic signed [VEL_W-1:0]  in_vel_rot = '0;
  logic signed [VEL_W-1:0]  in_count_a = '0;
  logic signed [VEL_W-1:0]  in_count_b = '0;
  logic signed [VEL_W-1:0]  in_count_c = '0;
  logic signed [VEL_W-1:0]  in_count_d = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic        [DUTY_W-1:0] out_duty_a;
  logic        [DUTY_W-1:0] out_duty_b;
  logic        [DUTY_W-1:0] out_duty_c;
  logic        [DUTY_W-1:0] out_duty_d;
  logic                     out_fwd_a;
  logic                     out_fwd_b;
  logic                     out_fwd_c;
  logic                     out_fwd_d;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic        [IDX_W-1:0]  cfg_index = '0;
  logic        [GAIN_W-1:0] cfg_data = '0;

  logic signed [GAIN_W-1:0] cur_gain_p = GAIN_P_RST;
  logic signed [GAIN_W-1:0] cur_gain_i = GAIN_I_RST;
  logic        [GEOM_W-1:0] cur_geometry = GEOMETRY_RST;
  logic        [LIM_W-1:0]  cur_pi_limit = PI_LIMIT_RST;
  logic        [LIM_W-1:0]  cur_drive_limit = DRIVE_LIMIT_RST;

  logic signed [ACC_W-1:0]  wheel_acc [WHEELS] = '{default: '0};
  logic signed [BIAS_W-1:0] wheel_last_bias [WHEELS] = '{default: '0};

  tick_cmd_t    pending_ticks [$];
  wheel_drive_t expected_drives [$];

  int    in_idle_pct = 0;
  int    out_idle_pct = 0;
  int    in_gap = 0;
  int    out_gap = 0;
  int    idle_cycles = 0;
  int    n_ticks = 0;
  int    n_drives = 0;
  int    n_writes = 0;
  int    n_settings = 0;
  int    n_errors = 0;
  string wheel_tag = "ABCD";

  mecanum_wheel_pi_speed_control_core #(
    .GAIN_FRAC_BITS(GAIN_FRAC)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_vel_x   (in_vel_x),
    .in_vel_y   (in_vel_y),
    .in_vel_rot (in_vel_rot),
    .in_count_a (in_count_a),
    .in_count_b (in_count_b),
    .in_count_c (in_count_c),
    .in_count_d (in_count_d),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_duty_a (out_duty_a),
    .out_duty_b (out_duty_b),
    .out_duty_c (out_duty_c),
    .out_duty_d (out_duty_d),
    .out_fwd_a  (out_fwd_a),
    .out_fwd_b  (out_fwd_b),
    .out_fwd_c  (out_fwd_c),
    .out_fwd_d  (out_fwd_d),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic longint clamp_sym(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Targets and one incremental PI update per wheel; advances the loop state.
  function automatic wheel_drive_t wheel_pi_step(input tick_cmd_t t);
    wheel_drive_t r;
    longint vx, vy, rot, lin, tgt, bias, sum, acc, drv;
    longint geom_one, gain_one;
    geom_one = longint'(1) << GEOM_FRAC_BITS;
    gain_one = longint'(1) << GAIN_FRAC;
    vx = longint'($signed(t.vel_x));
    vy = longint'($signed(t.vel_y));
    rot = longint'($signed(t.vel_rot)) * longint'(cur_geometry);
    for (int w = 0; w < WHEELS; w++) begin
      lin = (SIGN_X_NEG[w] ? -vx : vx) + vy;
      tgt = (lin * geom_one + (SIGN_Z_NEG[w] ? -rot : rot)) / geom_one;
      bias = longint'($signed(t.count[w])) - tgt;
      sum = longint'(wheel_acc[w]) * gain_one
            + longint'(cur_gain_p) * (bias - longint'(wheel_last_bias[w]))
            + longint'(cur_gain_i) * bias;
      acc = clamp_sym(sum / gain_one, longint'(cur_pi_limit));
      drv = clamp_sym(acc, longint'(cur_drive_limit));
      wheel_acc[w] = ACC_W'(acc);
      wheel_last_bias[w] = BIAS_W'(bias);
      r.duty[w] = DUTY_W'(drv < 0 ? -drv : drv);
      r.fwd[w] = (drv > 0);
    end
    return r;
  endfunction

  function automatic tick_cmd_t make_tick();
    tick_cmd_t t;
    int vx, vy;
    if ($urandom_range(0, 4) == 0) begin
      t = CMD_W'({$urandom, $urandom, $urandom, $urandom});
    end else begin
      vx = int'($urandom_range(0, 4000)) - 2000;
      vy = int'($urandom_range(0, 4000)) - 2000;
      t.vel_x = VEL_W'(vx);
      t.vel_y = VEL_W'(vy);
      t.vel_rot = VEL_W'(int'($urandom_range(0, 4000)) - 2000);
      for (int w = 0; w < WHEELS; w++) begin
        t.count[w] = VEL_W'((SIGN_X_NEG[w] ? -vx : vx) + vy
                            + int'($urandom_range(0, 128)) - 64);
      end
    end
    return t;
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return GAIN_W'($urandom);
      default: return GAIN_W'(int'($urandom_range(0, 2048)) - 1024);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_limit();
    logic [LIM_W-1:0] lim;
    case ($urandom_range(0, 5))
      0: lim = '0;
      1: lim = '1;
      default: lim = LIM_W'($urandom_range(0, 16383));
    endcase
    return {2'($urandom_range(0, 3)), lim};
  endfunction

  function automatic logic [GAIN_W-1:0] pick_geometry();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      default: return GEOM_W'($urandom);
    endcase
  endfunction

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_GAIN_P:      cur_gain_p = data;
      REG_GAIN_I:      cur_gain_i = data;
      REG_GEOMETRY:    cur_geometry = data;
      REG_PI_LIMIT:    cur_pi_limit = data[LIM_W-1:0];
      REG_DRIVE_LIMIT: cur_drive_limit = data[LIM_W-1:0];
      default: ;
    endcase
    n_writes++;
  endtask

  task automatic send_tick(input logic [VEL_W-1:0] vx, vy, vr, ca, cb, cc, cd);
    tick_cmd_t t;
    t.vel_x = vx;
    t.vel_y = vy;
    t.vel_rot = vr;
    t.count = {cd, cc, cb, ca};
    pending_ticks.push_back(t);
  endtask

  task automatic drain();
    while (pending_ticks.size() != 0 || in_valid || expected_drives.size() != 0)
      @(negedge clk);
  endtask

  // Driver
  always @(posedge clk) begin : drive_ticks
    tick_cmd_t seen, nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        seen.vel_x = in_vel_x;
        seen.vel_y = in_vel_y;
        seen.vel_rot = in_vel_rot;
        seen.count = {in_count_d, in_count_c, in_count_b, in_count_a};
        expected_drives.push_back(wheel_pi_step(seen));
        n_ticks++;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap != 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (int'($urandom_range(0, 99)) < in_idle_pct) begin
          in_gap <= $urandom_range(0, 9);
          in_valid <= 1'b0;
        end else if (pending_ticks.size() != 0) begin
          nxt = pending_ticks.pop_front();
          in_vel_x <= nxt.vel_x;
          in_vel_y <= nxt.vel_y;
          in_vel_rot <= nxt.vel_rot;
          in_count_a <= nxt.count[0];
          in_count_b <= nxt.count[1];
          in_count_c <= nxt.count[2];
          in_count_d <= nxt.count[3];
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_gap <= 0;
    end else if (out_gap != 0) begin
      out_gap <= out_gap - 1;
      out_stall <= 1'b1;
    end else if (int'($urandom_range(0, 99)) < out_idle_pct) begin
      out_gap <= $urandom_range(0, 9);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor
  always @(posedge clk) begin : check_drives
    wheel_drive_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got.duty = {out_duty_d, out_duty_c, out_duty_b, out_duty_a};
      got.fwd = {out_fwd_d, out_fwd_c, out_fwd_b, out_fwd_a};
      n_drives++;
      if (expected_drives.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected drive transaction duty %h fwd %b",
                 $time, got.duty, got.fwd);
      end else begin
        want = expected_drives.pop_front();
        for (int w = 0; w < WHEELS; w++) begin
          if (got.duty[w] !== want.duty[w]) begin
            n_errors++;
            $display("%0t: duty_%c expected %0d actual %0d",
                     $time, wheel_tag[w], want.duty[w], got.duty[w]);
          end
          if (got.fwd[w] !== want.fwd[w]) begin
            n_errors++;
            $display("%0t: fwd_%c expected %0d actual %0d",
                     $time, wheel_tag[w], want.fwd[w], got.fwd[w]);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    in_idle_pct = 15;
    out_idle_pct = 15;
    n_settings++;
    send_tick('0, '0, '0, '0, '0, '0, '0);
    send_tick(VEL_MAX, VEL_MAX, VEL_MAX, VEL_MIN, VEL_MIN, VEL_MIN, VEL_MIN);
    send_tick(VEL_MIN, VEL_MIN, VEL_MIN, VEL_MAX, VEL_MAX, VEL_MAX, VEL_MAX);
    send_tick(VEL_MAX, VEL_MIN, VEL_MAX, '0, VEL_ONES, VEL_MAX, VEL_MIN);
    send_tick('0, '0, '0, 16'd5, -16'sd5, 16'd1, -16'sd1);
    send_tick('0, '0, '0, 16'd5, -16'sd5, 16'd1, -16'sd1);
    send_tick('0, '0, '0, '0, '0, '0, '0);
    drain();

    // unknown indexes must leave every register alone
    write_reg(REG_DRIVE_LIMIT + 3'd1, '0);
    write_reg(REG_DRIVE_LIMIT + 3'd2, '0);
    write_reg(REG_DRIVE_LIMIT + 3'd3, '0);
    @(negedge clk);
    send_tick(16'd40, -16'sd30, 16'd100, 16'd7, -16'sd9, 16'd60, -16'sd3);
    send_tick(16'd40, -16'sd30, 16'd100, 16'd2, '0, 16'd50, 16'd1);
    drain();

    write_reg(REG_PI_LIMIT, 16'hFFFF);
    write_reg(REG_DRIVE_LIMIT, 16'hC000);
    n_settings++;
    @(negedge clk);
    send_tick('0, '0, '0, VEL_MIN, VEL_MAX, VEL_MIN, VEL_MAX);
    send_tick('0, '0, '0, VEL_MIN, VEL_MAX, VEL_MIN, VEL_MAX);
    drain();

    write_reg(REG_DRIVE_LIMIT, 16'h3FFF);
    n_settings++;
    @(negedge clk);
    send_tick('0, '0, '0, VEL_MIN, VEL_MAX, VEL_MIN, VEL_MAX);
    send_tick('0, '0, '0, VEL_MIN, VEL_MAX, VEL_MIN, VEL_MAX);
    drain();

    write_reg(REG_PI_LIMIT, 16'd50);
    n_settings++;
    @(negedge clk);
    send_tick('0, '0, '0, VEL_MIN, VEL_MAX, VEL_MIN, VEL_MAX);
    drain();

    write_reg(REG_PI_LIMIT, '0);
    n_settings++;
    @(negedge clk);
    send_tick(16'd300, 16'd200, 16'd100, 16'd9, -16'sd9, VEL_MAX, VEL_MIN);
    drain();

    write_reg(REG_GAIN_P, 16'h8000);
    write_reg(REG_GAIN_I, 16'h7FFF);
    write_reg(REG_GEOMETRY, 16'hFFFF);
    write_reg(REG_PI_LIMIT, 16'd8400);
    n_settings++;
    @(negedge clk);
    send_tick('0, '0, VEL_MAX, '0, '0, '0, '0);
    send_tick('0, '0, VEL_MIN, 16'd3, -16'sd3, 16'd3, -16'sd3);
    send_tick(16'd1, 16'd1, VEL_ONES, '0, '0, '0, '0);
    drain();

    write_reg(REG_GEOMETRY, '0);
    n_settings++;
    @(negedge clk);
    send_tick(16'd10, 16'd20, VEL_MAX, 16'd30, 16'd30, 16'd10, 16'd10);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      write_reg(REG_GAIN_P, pick_gain());
      write_reg(REG_GAIN_I, pick_gain());
      write_reg(REG_GEOMETRY, pick_geometry());
      write_reg(REG_PI_LIMIT, pick_limit());
      write_reg(REG_DRIVE_LIMIT, pick_limit());
      if ($urandom_range(0, 2) == 0)
        write_reg(REG_DRIVE_LIMIT + 3'($urandom_range(1, 3)), GAIN_W'($urandom));
      n_settings++;
      if (ph == PHASES - 1) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct = 8 * int'($urandom_range(0, 3));
        out_idle_pct = 8 * int'($urandom_range(0, 3));
      end
      @(negedge clk);
      repeat (PHASE_TICKS) pending_ticks.push_back(make_tick());
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run covered %0d control ticks and %0d drive results over %0d settings",
             n_ticks, n_drives, n_settings);
    $display("(%0d register writes, %0d mismatches)", n_writes, n_errors);
    if (n_errors == 0 && expected_drives.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
